// ===== hdl/mpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared constants and controller/datapath signal groups of the draw unit.
// ----------------------------------------------------------------------------
package mpfd_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam int ROWS_TALL  = 64;
    localparam int ROWS_SHORT = 32;
    localparam int PAGE_ROWS  = 8;

    localparam logic [2:0] OP_PIXEL   = 3'd0;
    localparam logic [2:0] OP_LINE    = 3'd1;
    localparam logic [2:0] OP_FILL    = 3'd2;
    localparam logic [2:0] OP_OUTLINE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    typedef struct packed {
        logic load;
        logic start;
        logic seg_next;
        logic rd;
        logic wr;
        logic step;
        logic clr;
        logic res_load;
    } mpfd_ctl_t;

    typedef struct packed {
        logic clr_last;
        logic walk_done;
        logic pix_in;
        logic is_walk;
        logic outline_more;
        logic out_busy;
    } mpfd_sts_t;

endpackage

// ===== hdl/mpfd_if.sv =====
// ----------------------------------------------------------------------------
// mpfd_if
// Valid/ready channels of the draw unit: command, response, configuration.
// ----------------------------------------------------------------------------
interface mpfd_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] x_a;
    logic [7:0] y_a;
    logic [7:0] x_b;
    logic [7:0] y_b;
    logic       color;

    modport source (output valid, op, x_a, y_a, x_b, y_b, color, input ready);
    modport sink   (input valid, op, x_a, y_a, x_b, y_b, color, output ready);
endinterface

interface mpfd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;

    modport source (output valid, read_byte, input ready);
    modport sink   (input valid, read_byte, output ready);
endinterface

interface mpfd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/mpfd_ram.sv =====
// ----------------------------------------------------------------------------
// mpfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/mpfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpfd_ctrl
// Sequencer: store clear pass, command dispatch, pixel read-modify-write.
// ----------------------------------------------------------------------------
module mpfd_ctrl
    import mpfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mpfd_sts_t sts,
    output mpfd_ctl_t ctl
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_PIX_WR,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                ctl.start = 1'b1;
                ctl.rd    = !sts.is_walk;
                state_next = sts.is_walk ? ST_WALK : ST_RESULT;
            end
            ST_WALK:
            begin
                priority if (sts.walk_done && sts.outline_more)
                begin
                    ctl.seg_next = 1'b1;
                end
                else if (sts.walk_done)
                begin
                    state_next = ST_RESULT;
                end
                else if (sts.pix_in)
                begin
                    ctl.rd     = 1'b1;
                    state_next = ST_PIX_WR;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            ST_PIX_WR:
            begin
                ctl.wr     = 1'b1;
                ctl.step   = 1'b1;
                state_next = ST_WALK;
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/mpfd_dpath.sv =====
// ----------------------------------------------------------------------------
// mpfd_dpath
// Command registers, line and fill walkers, frame store and result register.
// ----------------------------------------------------------------------------
module mpfd_dpath
    import mpfd_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mpfd_cmd_if.sink   cmd,
    mpfd_rsp_if.source rsp,
    mpfd_cfg_if.sink   cfg,
    input  mpfd_ctl_t  ctl,
    output mpfd_sts_t  sts
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int H_TALL  = (ROWS_TALL < PAGES * PAGE_ROWS) ? ROWS_TALL : PAGES * PAGE_ROWS;
    localparam int H_SHORT = (ROWS_SHORT < PAGES * PAGE_ROWS) ? ROWS_SHORT : PAGES * PAGE_ROWS;
    localparam logic [8:0]        COL_LIM   = 9'(COLUMNS);
    localparam logic [8:0]        PAGE_LIM  = 9'(PAGES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [2:0]  op_reg;
    logic [7:0]  xa_reg, ya_reg, xb_reg, yb_reg;
    logic        color_reg;
    logic        hit_reg;
    logic        tall_reg;
    logic [7:0]  x_reg, y_reg, cnt_reg;
    logic signed [11:0] d_reg;
    logic        steep_reg, sxn_reg, syn_reg, done_reg;
    logic [8:0]  maj2_reg, min2_reg;
    logic [1:0]  seg_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;

    logic [1:0]  sel;
    logic [7:0]  p0x, p0y, p1x, p1y, dx, dy, major, minor;
    logic        steep;
    logic signed [11:0] d_init;
    logic [8:0]  h_lim;
    logic [12:0] pix_full;
    logic [16:0] byte_full;
    logic [ADDR_W-1:0] pix_addr, waddr, raddr;
    logic [7:0]  wdata, rdata, mask;

    function automatic logic [7:0] move(input logic [7:0] v, input logic neg);
        return neg ? v - 8'd1 : v + 8'd1;
    endfunction

    assign sel = ctl.start ? 2'd0 : seg_reg + 2'd1;

    always_comb
    begin
        unique case (sel)
            2'd0:
            begin
                p0x = xa_reg;
                p0y = ya_reg;
                p1x = xb_reg;
                p1y = (op_reg == OP_LINE) ? yb_reg : ya_reg;
            end
            2'd1:
            begin
                p0x = xb_reg; p0y = ya_reg; p1x = xb_reg; p1y = yb_reg;
            end
            2'd2:
            begin
                p0x = xb_reg; p0y = yb_reg; p1x = xa_reg; p1y = yb_reg;
            end
            default:
            begin
                p0x = xa_reg; p0y = yb_reg; p1x = xa_reg; p1y = ya_reg;
            end
        endcase
    end

    assign dx     = (p1x > p0x) ? p1x - p0x : p0x - p1x;
    assign dy     = (p1y > p0y) ? p1y - p0y : p0y - p1y;
    assign steep  = dy > dx;
    assign major  = steep ? dy : dx;
    assign minor  = steep ? dx : dy;
    assign d_init = $signed({3'b000, minor, 1'b0}) - $signed({4'b0000, major});

    assign h_lim     = tall_reg ? 9'(H_TALL) : 9'(H_SHORT);
    assign pix_full  = 13'(y_reg[7:3]) * 13'(COLUMNS) + 13'(x_reg);
    assign pix_addr  = pix_full[ADDR_W-1:0];
    assign byte_full = 17'(ya_reg) * 17'(COLUMNS) + 17'(xa_reg);
    assign mask      = 8'(1) << y_reg[2:0];

    assign waddr = ctl.clr ? clr_reg : pix_addr;
    assign raddr = (op_reg == OP_READ) ? byte_full[ADDR_W-1:0] : pix_addr;
    assign wdata = ctl.clr ? 8'd0 : (color_reg ? (rdata | mask) : (rdata & ~mask));

    mpfd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctl.clr | ctl.wr),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sts.clr_last     = (clr_reg == LAST_ADDR);
    assign sts.walk_done    = done_reg;
    assign sts.pix_in       = ({1'b0, x_reg} < COL_LIM) && ({1'b0, y_reg} < h_lim);
    assign sts.is_walk      = (op_reg <= OP_OUTLINE);
    assign sts.outline_more = (op_reg == OP_OUTLINE) && (seg_reg != 2'd3);
    assign sts.out_busy     = out_valid_reg && !rsp.ready;

    assign cmd.ready     = 1'b0 | ctl.load;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_byte = out_byte_reg;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tall_reg      <= 1'b1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b1;
        end
        else
        begin
            if (cfg.valid)
            begin
                tall_reg <= cfg.data;
            end
            if (ctl.clr)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (ctl.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.start && op_reg == OP_PIXEL)
            begin
                done_reg <= 1'b0;
            end
            else if (ctl.start && op_reg == OP_FILL)
            begin
                done_reg <= (xa_reg >= xb_reg) || (ya_reg >= yb_reg);
            end
            else if (ctl.start || ctl.seg_next)
            begin
                done_reg <= (major == 8'd0);
            end
            else if (ctl.step && op_reg == OP_FILL)
            begin
                done_reg <= (x_reg == xb_reg - 8'd1) && (y_reg == yb_reg - 8'd1);
            end
            else if (ctl.step)
            begin
                done_reg <= (cnt_reg == 8'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= cmd.op;
            xa_reg    <= cmd.x_a;
            ya_reg    <= cmd.y_a;
            xb_reg    <= cmd.x_b;
            yb_reg    <= cmd.y_b;
            color_reg <= cmd.color;
            hit_reg   <= (cmd.op == OP_READ) && ({1'b0, cmd.x_a} < COL_LIM)
                         && ({1'b0, cmd.y_a} < PAGE_LIM);
        end
        if (ctl.res_load)
        begin
            out_byte_reg <= hit_reg ? rdata : 8'd0;
        end
        if (ctl.start && (op_reg == OP_PIXEL || op_reg == OP_FILL))
        begin
            x_reg   <= xa_reg;
            y_reg   <= ya_reg;
            cnt_reg <= 8'd1;
            d_reg   <= '0;
            seg_reg <= 2'd3;
        end
        else if (ctl.start || ctl.seg_next)
        begin
            x_reg     <= p0x;
            y_reg     <= p0y;
            cnt_reg   <= major;
            d_reg     <= d_init;
            steep_reg <= steep;
            sxn_reg   <= !(p1x > p0x);
            syn_reg   <= !(p1y > p0y);
            maj2_reg  <= {major, 1'b0};
            min2_reg  <= {minor, 1'b0};
            seg_reg   <= sel;
        end
        else if (ctl.step && op_reg == OP_FILL)
        begin
            if (x_reg == xb_reg - 8'd1)
            begin
                x_reg <= xa_reg;
                y_reg <= y_reg + 8'd1;
            end
            else
            begin
                x_reg <= x_reg + 8'd1;
            end
        end
        else if (ctl.step)
        begin
            cnt_reg <= cnt_reg - 8'd1;
            if (d_reg > 12'sd0)
            begin
                d_reg <= d_reg - $signed({3'b000, maj2_reg}) + $signed({3'b000, min2_reg});
                if (steep_reg)
                begin
                    x_reg <= move(x_reg, sxn_reg);
                end
                else
                begin
                    y_reg <= move(y_reg, syn_reg);
                end
            end
            else
            begin
                d_reg <= d_reg + $signed({3'b000, min2_reg});
            end
            if (steep_reg)
            begin
                y_reg <= move(y_reg, syn_reg);
            end
            else
            begin
                x_reg <= move(x_reg, sxn_reg);
            end
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |-> !sts.out_busy)
        else $error("result overwritten while pending");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr |-> $past(ctl.rd))
        else $error("pixel write without prior read");

    a_wr_same_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr |-> ($stable(x_reg) && $stable(y_reg)))
        else $error("pixel moved between read and write");

    a_no_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |-> !(cmd.valid && cmd.ready))
        else $error("command taken during clear pass");

endmodule

// ===== hdl/mono_page_framebuffer_draw_unit.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_unit
// Draws pixels, lines and rectangles into a monochrome page store and reads its bytes back.
//
//  channel | modport | payload                          | transaction
//  cmd     | sink    | op, x_a, y_a, x_b, y_b, color    | valid & ready
//  rsp     | source  | read_byte                        | valid & ready
//  cfg     | sink    | data (tall_mode)                 | valid & ready
//
//  After reset a clear pass zeroes the store; no commands are taken during it.
//  Each visible pixel is a read-modify-write of its store byte; dropped pixels are skipped.
//  An outline walks its four sides in turn; a read fetches one store byte for rsp.
//  A stalled response holds; the next command is taken while it waits.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_unit
    import mpfd_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mpfd_cmd_if.sink   cmd,
    mpfd_rsp_if.source rsp,
    mpfd_cfg_if.sink   cfg
);

    mpfd_ctl_t ctl;
    mpfd_sts_t sts;
    logic      in_ready;

    mpfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    mpfd_dpath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctl   (ctl),
        .sts   (sts)
    );

    a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && in_ready) |-> ctl.load)
        else $error("ready command not loaded");

endmodule
